// ===== hdl/izoc_pkg.sv =====
// Shared types and constants for the IMU zero offset calibrator.
package izoc_pkg;

  localparam int AXIS_W         = 16;
  localparam int SUM_W          = 25;
  localparam int PASS_W         = 10;
  localparam int ONE_G_W        = 15;
  localparam int NUM_AXES       = 3;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;
  localparam int CAL_PASSES_DEF = 200;

  localparam logic [ONE_G_W-1:0] ONE_G_RESET = ONE_G_W'(8192);

  localparam logic REG_ACCEL_ONE_G = 1'b0;

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef enum logic [1:0] {
    ACT_SAMPLE    = 2'd0,
    ACT_ARM_BOTH  = 2'd1,
    ACT_ARM_GYRO  = 2'd2,
    ACT_ARM_ACCEL = 2'd3
  } action_t;

  typedef struct packed {
    action_t             action;
    logic signed [15:0]  accel_x_raw;
    logic signed [15:0]  accel_y_raw;
    logic signed [15:0]  accel_z_raw;
    logic signed [15:0]  gyro_x_raw;
    logic signed [15:0]  gyro_y_raw;
    logic signed [15:0]  gyro_z_raw;
  } sample_t;

  typedef struct packed {
    logic signed [15:0]  accel_x_fixed;
    logic signed [15:0]  accel_y_fixed;
    logic signed [15:0]  accel_z_fixed;
    logic signed [15:0]  gyro_x_fixed;
    logic signed [15:0]  gyro_y_fixed;
    logic signed [15:0]  gyro_z_fixed;
    logic                gyro_cal_done;
    logic                accel_cal_done;
    logic                cal_busy;
  } result_t;

endpackage

// ===== hdl/imu_zero_offset_calibrator.sv =====
// IMU zero offset calibrator: offset removal and averaging calibration, top level.
// An accepted item's result goes to the output register, or to the skid stage while the output is stalled.
// Throughput: one item per cycle while the skid stage is empty; a skid stage keeps input ready for one stalled result.
// New offsets are divided from a snapshot register and committed in the cycle after
// the last pass; the constant divide uses one multiplier per axis.
// Synchronous active-high reset clears offsets, sums, pass count and arming, and sets accel_one_g to 8192.
module imu_zero_offset_calibrator
  import izoc_pkg::*;
#(
  parameter int CAL_PASSES = CAL_PASSES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_ready,
  input  sample_t               sample,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [ONE_G_W-1:0] accel_one_g;
  axis_t              gyro_offsets [NUM_AXES];
  axis_t              accel_offsets[NUM_AXES];
  sum_t               axis_sums    [NUM_AXES];
  sum_t               snap         [NUM_AXES];
  logic [PASS_W-1:0]  pass_count;
  logic               gyro_armed;
  logic               accel_armed;
  logic               pend_gyro;
  logic               pend_accel;

  axis_t              gyro_offsets_next [NUM_AXES];
  axis_t              accel_offsets_next[NUM_AXES];
  sum_t               axis_sums_next    [NUM_AXES];
  sum_t               snap_next         [NUM_AXES];
  logic [PASS_W-1:0]  pass_count_next;
  logic               gyro_armed_next;
  logic               accel_armed_next;
  logic               pend_gyro_next;
  logic               pend_accel_next;

  result_t            skid;
  logic               skid_valid;
  result_t            item_result;

  axis_t              quot      [NUM_AXES];
  axis_t              raw_a     [NUM_AXES];
  axis_t              raw_g     [NUM_AXES];
  axis_t              fix_a     [NUM_AXES];
  axis_t              fix_g     [NUM_AXES];
  sum_t               sum_g_add [NUM_AXES];
  sum_t               sum_a_add [NUM_AXES];
  logic [PASS_W-1:0]  pass_inc;
  logic               accept;
  logic               cfg_write;
  logic               gdone;
  logic               adone;

  assign accept       = sample_valid & sample_ready;
  assign sample_ready = ~skid_valid;
  assign pready       = 1'b1;
  assign cfg_write    = psel & penable & pwrite & pready;
  assign prdata       = (paddr[2] == REG_ACCEL_ONE_G) ?
                        APB_DATA_W'(accel_one_g) : '0;

  assign raw_a[0] = sample.accel_x_raw;
  assign raw_a[1] = sample.accel_y_raw;
  assign raw_a[2] = sample.accel_z_raw;
  assign raw_g[0] = sample.gyro_x_raw;
  assign raw_g[1] = sample.gyro_y_raw;
  assign raw_g[2] = sample.gyro_z_raw;

  assign pass_inc = pass_count + PASS_W'(1);

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
    izoc_div #(.DIVISOR(CAL_PASSES)) u_div (
      .sum  (snap[i]),
      .quot (quot[i])
    );

    assign fix_a[i] = raw_a[i] - (pend_accel ? quot[i] : accel_offsets[i]);
    assign fix_g[i] = raw_g[i] - (pend_gyro  ? quot[i] : gyro_offsets[i]);

    // running sums use the stored offsets: no pass that adds follows a pending commit
    assign sum_g_add[i] = axis_sums[i] + SUM_W'(axis_t'(raw_g[i] - gyro_offsets[i]));
    if (i == NUM_AXES - 1) begin : g_z
      assign sum_a_add[i] = axis_sums[i] + SUM_W'(axis_t'(raw_a[i] - accel_offsets[i]))
                            - sum_t'({1'b0, accel_one_g});
    end else begin : g_xy
      assign sum_a_add[i] = axis_sums[i] + SUM_W'(axis_t'(raw_a[i] - accel_offsets[i]));
    end
  end

  always_comb begin
    gyro_armed_next  = gyro_armed;
    accel_armed_next = accel_armed;
    pass_count_next  = pass_count;
    pend_gyro_next   = 1'b0;
    pend_accel_next  = 1'b0;
    gdone            = 1'b0;
    adone            = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      gyro_offsets_next[i]  = pend_gyro  ? quot[i] : gyro_offsets[i];
      accel_offsets_next[i] = pend_accel ? quot[i] : accel_offsets[i];
      axis_sums_next[i]     = axis_sums[i];
      snap_next[i]          = snap[i];
    end

    unique case (sample.action)
      ACT_ARM_BOTH: begin
        if (!gyro_armed_next) begin
          gyro_armed_next = 1'b1;
          pass_count_next = '0;
        end
        accel_armed_next = 1'b1;
      end
      ACT_ARM_GYRO: begin
        if (!gyro_armed_next) begin
          gyro_armed_next = 1'b1;
          pass_count_next = '0;
        end
      end
      ACT_ARM_ACCEL: accel_armed_next = 1'b1;
      default: ;
    endcase

    if (gyro_armed_next) begin
      if (pass_count_next == '0) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          axis_sums_next[i]    = '0;
          gyro_offsets_next[i] = '0;
        end
        pass_count_next = PASS_W'(1);
      end else begin
        for (int i = 0; i < NUM_AXES; i++) begin
          axis_sums_next[i] = sum_g_add[i];
        end
        pass_count_next = pass_inc;
        if (pass_inc == PASS_W'(CAL_PASSES)) begin
          for (int i = 0; i < NUM_AXES; i++) begin
            snap_next[i] = sum_g_add[i];
          end
          pend_gyro_next   = 1'b1;
          pass_count_next  = '0;
          gyro_armed_next  = 1'b0;
          accel_armed_next = 1'b1;
          gdone            = 1'b1;
        end
      end
    end

    if (accel_armed_next && !gyro_armed_next) begin
      if (pass_count_next == '0) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          axis_sums_next[i]     = '0;
          accel_offsets_next[i] = '0;
        end
        pass_count_next = PASS_W'(1);
      end else begin
        for (int i = 0; i < NUM_AXES; i++) begin
          axis_sums_next[i] = sum_a_add[i];
        end
        pass_count_next = pass_inc;
        if (pass_inc == PASS_W'(CAL_PASSES)) begin
          for (int i = 0; i < NUM_AXES; i++) begin
            snap_next[i] = sum_a_add[i];
          end
          pend_accel_next  = 1'b1;
          pass_count_next  = '0;
          accel_armed_next = 1'b0;
          adone            = 1'b1;
        end
      end
    end

    item_result.accel_x_fixed  = fix_a[0];
    item_result.accel_y_fixed  = fix_a[1];
    item_result.accel_z_fixed  = fix_a[2];
    item_result.gyro_x_fixed   = fix_g[0];
    item_result.gyro_y_fixed   = fix_g[1];
    item_result.gyro_z_fixed   = fix_g[2];
    item_result.gyro_cal_done  = gdone;
    item_result.accel_cal_done = adone;
    item_result.cal_busy       = gyro_armed_next | accel_armed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_one_g <= ONE_G_RESET;
      pass_count  <= '0;
      gyro_armed  <= 1'b0;
      accel_armed <= 1'b0;
      pend_gyro   <= 1'b0;
      pend_accel  <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        gyro_offsets[i]  <= '0;
        accel_offsets[i] <= '0;
        axis_sums[i]     <= '0;
      end
    end else begin
      if (cfg_write && paddr[2] == REG_ACCEL_ONE_G) begin
        accel_one_g <= pwdata[ONE_G_W-1:0];
      end
      if (accept) begin
        pass_count  <= pass_count_next;
        gyro_armed  <= gyro_armed_next;
        accel_armed <= accel_armed_next;
        pend_gyro   <= pend_gyro_next;
        pend_accel  <= pend_accel_next;
        for (int i = 0; i < NUM_AXES; i++) begin
          gyro_offsets[i]  <= gyro_offsets_next[i];
          accel_offsets[i] <= accel_offsets_next[i];
          axis_sums[i]     <= axis_sums_next[i];
        end
      end else begin
        pend_gyro  <= 1'b0;
        pend_accel <= 1'b0;
        for (int i = 0; i < NUM_AXES; i++) begin
          if (pend_gyro) begin
            gyro_offsets[i] <= quot[i];
          end
          if (pend_accel) begin
            accel_offsets[i] <= quot[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        snap[i] <= snap_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (!result_valid || result_ready) begin
        result_valid <= skid_valid | accept;
        skid_valid   <= 1'b0;
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || result_ready) begin
      result <= skid_valid ? skid : item_result;
    end else if (accept) begin
      skid <= item_result;
    end
  end

`ifndef SYNTHESIS
  a_done_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.gyro_cal_done && result.accel_cal_done))
    else $error("gyro and accel calibration finished in one item");

  a_pend_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(pend_gyro && pend_accel))
    else $error("two offset commits pending at once");

  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid stage holds an item while the result register is empty");

  a_gyro_done_arms_accel: assert property (@(posedge clk) disable iff (rst)
    accept && gdone |=> accel_armed && !gyro_armed)
    else $error("finished gyro calibration did not hand over to accel");
`endif

endmodule

// ===== hdl/izoc_div.sv =====
// Signed sum divided by a constant pass count, truncating toward zero.
module izoc_div
  import izoc_pkg::*;
#(
  parameter int DIVISOR = CAL_PASSES_DEF
) (
  input  sum_t  sum,
  output axis_t quot
);

  localparam int DIV_L   = $clog2(DIVISOR);
  localparam int RECIP_W = SUM_W + 1;
  localparam int SHIFT   = SUM_W + DIV_L;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) / 64'(DIVISOR)) + 64'd1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  logic              neg;
  logic [SUM_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [AXIS_W-1:0] qmag;

  assign neg  = sum[SUM_W-1];
  assign mag  = neg ? SUM_W'(-sum) : SUM_W'(sum);
  assign prod = PROD_W'(mag) * PROD_W'(RECIP);
  assign qmag = prod[SHIFT +: AXIS_W];
  assign quot = neg ? axis_t'(-qmag) : axis_t'(qmag);

endmodule
